### rtl/rcps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcps_pkg
// Shared types and constants for the RC channel scaler: field widths,
// register indexes, channel modes and the structs between the pipeline parts.
// ----------------------------------------------------------------------------
package rcps_pkg;

    localparam int PULSE_W         = 12;
    localparam int SCALE_W         = 16;
    localparam int DB_W            = 10;
    localparam int CTL_W           = 16;
    localparam int EXT_W           = 15;
    localparam int NUM_W           = 29;
    localparam int NMAG_W          = 28;
    localparam int DEN_W           = 17;
    localparam int DMAG_W          = 16;
    localparam int LANES           = 2;
    localparam int ADDR_W          = 5;
    localparam int DATA_W          = 32;
    localparam int FAILSAFE_MARGIN = 50;
    localparam int RAW_DIVISOR     = 10;

    typedef enum logic [1:0] {
        MODE_ANGLE     = 2'd0,
        MODE_RANGE     = 2'd1,
        MODE_RAW       = 2'd2,
        MODE_ANGLE_ALT = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        REG_CHANNEL_MODE = 3'd0,
        REG_SCALE_HIGH   = 3'd1,
        REG_SCALE_LOW    = 3'd2,
        REG_REVERSED     = 3'd3,
        REG_DEAD_BAND    = 3'd4,
        REG_PULSE_MIN    = 3'd5,
        REG_PULSE_MAX    = 3'd6,
        REG_PULSE_TRIM   = 3'd7
    } reg_idx_t;

    typedef struct packed {
        mode_t                      channel_mode;
        logic signed [SCALE_W-1:0]  scale_high;
        logic signed [SCALE_W-1:0]  scale_low;
        logic                       reversed;
        logic [DB_W-1:0]            dead_band;
        logic [PULSE_W-1:0]         pulse_min;
        logic [PULSE_W-1:0]         pulse_max;
        logic [PULSE_W-1:0]         pulse_trim;
    } cfg_t;

    typedef struct packed {
        logic                     valid;
        logic                     fs;
        logic                     gt;
        logic signed [NUM_W-1:0]  num0;
        logic signed [DEN_W-1:0]  den0;
        logic signed [NUM_W-1:0]  num1;
        logic signed [DEN_W-1:0]  den1;
    } div_in_t;

    typedef struct packed {
        logic                     valid;
        logic                     fs;
        logic                     gt;
        logic signed [NUM_W-1:0]  q0;
        logic signed [NUM_W-1:0]  q1;
    } div_out_t;

endpackage

### rtl/rcps_chan_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcps channel interfaces
// Valid/ready channels for the input words and the result words.
// ----------------------------------------------------------------------------
interface rcps_in_if;
    logic                                       valid;
    logic                                       ready;
    logic [rcps_pkg::PULSE_W-1:0]               pulse_in;
    logic signed [rcps_pkg::SCALE_W-1:0]        servo_cmd;

    modport source (output valid, output pulse_in, output servo_cmd, input ready);
    modport sink   (input valid, input pulse_in, input servo_cmd, output ready);
endinterface

interface rcps_out_if;
    logic                                       valid;
    logic                                       ready;
    logic signed [rcps_pkg::CTL_W-1:0]          control_value;
    logic                                       failsafe;
    logic [rcps_pkg::PULSE_W-1:0]               pulse_out;

    modport source (output valid, output control_value, output failsafe, output pulse_out,
                    input ready);
    modport sink   (input valid, input control_value, input failsafe, input pulse_out,
                    output ready);
endinterface

### rtl/rcps_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcps_regs
// APB-style configuration register file for the channel scaler.
// ----------------------------------------------------------------------------
module rcps_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [rcps_pkg::ADDR_W-1:0]    paddr,
    input  logic [rcps_pkg::DATA_W-1:0]    pwdata,
    output logic [rcps_pkg::DATA_W-1:0]    prdata,
    output logic                           pready,
    output rcps_pkg::cfg_t                 cfg
);

    rcps_pkg::cfg_t     cfg_reg;
    rcps_pkg::reg_idx_t idx;
    logic               wr_en;

    assign idx    = rcps_pkg::reg_idx_t'(paddr[rcps_pkg::ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.channel_mode <= rcps_pkg::MODE_ANGLE;
            cfg_reg.scale_high   <= 16'sd4500;
            cfg_reg.scale_low    <= 16'sd0;
            cfg_reg.reversed     <= 1'b0;
            cfg_reg.dead_band    <= 10'd0;
            cfg_reg.pulse_min    <= 12'd1100;
            cfg_reg.pulse_max    <= 12'd1900;
            cfg_reg.pulse_trim   <= 12'd1500;
        end
        else if (wr_en)
        begin
            case (idx)
                rcps_pkg::REG_CHANNEL_MODE: cfg_reg.channel_mode <= rcps_pkg::mode_t'(pwdata[1:0]);
                rcps_pkg::REG_SCALE_HIGH:   cfg_reg.scale_high   <= pwdata[15:0];
                rcps_pkg::REG_SCALE_LOW:    cfg_reg.scale_low    <= pwdata[15:0];
                rcps_pkg::REG_REVERSED:     cfg_reg.reversed     <= pwdata[0];
                rcps_pkg::REG_DEAD_BAND:    cfg_reg.dead_band    <= pwdata[9:0];
                rcps_pkg::REG_PULSE_MIN:    cfg_reg.pulse_min    <= pwdata[11:0];
                rcps_pkg::REG_PULSE_MAX:    cfg_reg.pulse_max    <= pwdata[11:0];
                rcps_pkg::REG_PULSE_TRIM:   cfg_reg.pulse_trim   <= pwdata[11:0];
                default:                    cfg_reg              <= cfg_reg;
            endcase
        end
    end

    // Signed registers read back sign-extended.
    always_comb
    begin
        case (idx)
            rcps_pkg::REG_CHANNEL_MODE: prdata = {30'd0, cfg_reg.channel_mode};
            rcps_pkg::REG_SCALE_HIGH:   prdata = {{16{cfg_reg.scale_high[15]}}, cfg_reg.scale_high};
            rcps_pkg::REG_SCALE_LOW:    prdata = {{16{cfg_reg.scale_low[15]}}, cfg_reg.scale_low};
            rcps_pkg::REG_REVERSED:     prdata = {31'd0, cfg_reg.reversed};
            rcps_pkg::REG_DEAD_BAND:    prdata = {22'd0, cfg_reg.dead_band};
            rcps_pkg::REG_PULSE_MIN:    prdata = {20'd0, cfg_reg.pulse_min};
            rcps_pkg::REG_PULSE_MAX:    prdata = {20'd0, cfg_reg.pulse_max};
            rcps_pkg::REG_PULSE_TRIM:   prdata = {20'd0, cfg_reg.pulse_trim};
            default:                    prdata = '0;
        endcase
    end

endmodule

### rtl/rcps_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcps_front
// Three stages that turn a pulse and a command into dividend/divisor pairs:
// clamp, operand selection, multiply.
// ----------------------------------------------------------------------------
module rcps_front (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 adv,
    input  rcps_pkg::cfg_t                       cfg,
    input  logic                                 in_valid,
    input  logic [rcps_pkg::PULSE_W-1:0]         pulse_in,
    input  logic signed [rcps_pkg::SCALE_W-1:0]  servo_cmd,
    output rcps_pkg::div_in_t                    dout
);

    localparam int EW   = rcps_pkg::EXT_W;
    localparam int PW   = rcps_pkg::PULSE_W;
    localparam int SW   = rcps_pkg::SCALE_W;
    localparam int MW   = rcps_pkg::DEN_W;
    localparam int NW   = rcps_pkg::NUM_W;
    localparam logic signed [EW-1:0] MARGIN_E = EW'(rcps_pkg::FAILSAFE_MARGIN);
    localparam logic signed [EW-1:0] ONE_E    = EW'(1);
    localparam logic signed [MW-1:0] RAW_DEN  = MW'(rcps_pkg::RAW_DIVISOR);

    // Stage A
    logic                  a_vld_reg;
    logic [PW-1:0]         a_p_reg;
    logic [PW-1:0]         a_rc_reg;
    logic signed [SW-1:0]  a_s_reg;
    logic [PW-1:0]         rc;

    // Stage B
    logic                  b_vld_reg;
    logic                  b_fs_reg, b_gt_reg;
    logic signed [MW-1:0]  b_ma0_reg, b_ma1_reg, b_den0_reg, b_den1_reg;
    logic signed [EW-1:0]  b_mb0_reg, b_mb1_reg;

    logic signed [EW-1:0]  p_e, rc_e, min_e, max_e, trim_e, db_e, tl_e, r_e;
    logic signed [EW-1:0]  d_rng, d_ang, mb1_ang;
    logic signed [MW-1:0]  sh_e, sl_e, s_e;
    logic signed [MW-1:0]  ma0_next, ma1_next, den0_next, den1_next;
    logic signed [EW-1:0]  mb0_next, mb1_next;
    logic                  fs_next, gt_next;

    // Stage C
    logic                    c_vld_reg;
    logic                    c_fs_reg, c_gt_reg;
    logic signed [NW-1:0]    c_num0_reg, c_num1_reg;
    logic signed [MW-1:0]    c_den0_reg, c_den1_reg;
    logic signed [MW+EW-1:0] prod0, prod1;

    assign rc = (pulse_in <= cfg.pulse_min) ? cfg.pulse_min :
                (pulse_in >= cfg.pulse_max) ? cfg.pulse_max : pulse_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_vld_reg <= in_valid;
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= b_vld_reg;
        end
    end

    always_comb
    begin
        p_e    = $signed({{(EW-PW){1'b0}}, a_p_reg});
        rc_e   = $signed({{(EW-PW){1'b0}}, a_rc_reg});
        min_e  = $signed({{(EW-PW){1'b0}}, cfg.pulse_min});
        max_e  = $signed({{(EW-PW){1'b0}}, cfg.pulse_max});
        trim_e = $signed({{(EW-PW){1'b0}}, cfg.pulse_trim});
        db_e   = $signed({{(EW-rcps_pkg::DB_W){1'b0}}, cfg.dead_band});
        sh_e   = {{(MW-SW){cfg.scale_high[SW-1]}}, cfg.scale_high};
        sl_e   = {{(MW-SW){cfg.scale_low[SW-1]}}, cfg.scale_low};
        s_e    = {{(MW-SW){a_s_reg[SW-1]}}, a_s_reg};

        tl_e    = min_e + db_e;
        r_e     = cfg.reversed ? (max_e + min_e - rc_e) : rc_e;
        gt_next = r_e > tl_e;
        fs_next = p_e < (min_e - MARGIN_E);
        d_rng   = max_e - tl_e;
        d_ang   = (p_e < trim_e) ? (trim_e - min_e) : (max_e - trim_e);
        mb1_ang = (a_s_reg > 0) ? (max_e - trim_e) : (trim_e - min_e);

        if (cfg.channel_mode == rcps_pkg::MODE_RANGE)
        begin
            ma0_next  = sh_e - sl_e;
            mb0_next  = r_e - tl_e;
            den0_next = {{(MW-EW){d_rng[EW-1]}}, d_rng};
        end
        else
        begin
            ma0_next  = sh_e;
            mb0_next  = p_e - trim_e;
            den0_next = {{(MW-EW){d_ang[EW-1]}}, d_ang};
        end

        case (cfg.channel_mode)
            rcps_pkg::MODE_RANGE:
            begin
                ma1_next  = s_e - sl_e;
                mb1_next  = max_e - min_e;
                den1_next = sh_e - sl_e;
            end
            rcps_pkg::MODE_RAW:
            begin
                ma1_next  = s_e;
                mb1_next  = ONE_E;
                den1_next = RAW_DEN;
            end
            default:
            begin
                ma1_next  = s_e;
                mb1_next  = mb1_ang;
                den1_next = sh_e;
            end
        endcase
    end

    assign prod0 = b_ma0_reg * b_mb0_reg;
    assign prod1 = b_ma1_reg * b_mb1_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_p_reg    <= pulse_in;
            a_rc_reg   <= rc;
            a_s_reg    <= servo_cmd;

            b_fs_reg   <= fs_next;
            b_gt_reg   <= gt_next;
            b_ma0_reg  <= ma0_next;
            b_mb0_reg  <= mb0_next;
            b_den0_reg <= den0_next;
            b_ma1_reg  <= ma1_next;
            b_mb1_reg  <= mb1_next;
            b_den1_reg <= den1_next;

            c_fs_reg   <= b_fs_reg;
            c_gt_reg   <= b_gt_reg;
            c_num0_reg <= prod0[NW-1:0];
            c_den0_reg <= b_den0_reg;
            c_num1_reg <= prod1[NW-1:0];
            c_den1_reg <= b_den1_reg;
        end
    end

    assign dout = '{valid: c_vld_reg, fs: c_fs_reg, gt: c_gt_reg,
                    num0: c_num0_reg, den0: c_den0_reg,
                    num1: c_num1_reg, den1: c_den1_reg};

endmodule

### rtl/rcps_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcps_div
// Two-lane pipelined signed divider, one quotient bit per stage.
// Quotients truncate toward zero; a zero divisor gives zero.
// ----------------------------------------------------------------------------
module rcps_div (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  adv,
    input  rcps_pkg::div_in_t     din,
    output rcps_pkg::div_out_t    dout
);

    localparam int NW = rcps_pkg::NUM_W;
    localparam int NM = rcps_pkg::NMAG_W;
    localparam int DW = rcps_pkg::DEN_W;
    localparam int DM = rcps_pkg::DMAG_W;
    localparam int LN = rcps_pkg::LANES;

    logic signed [NW-1:0] num_l [LN];
    logic signed [DW-1:0] den_l [LN];
    logic signed [NW-1:0] num_neg [LN];
    logic signed [DW-1:0] den_neg [LN];
    logic [NM-1:0]        nmag [LN];
    logic [DM-1:0]        dmag [LN];

    logic [NM-1:0]        n_reg   [LN][NM+1];
    logic [DM-1:0]        r_reg   [LN][NM+1];
    logic [DM-1:0]        d_reg   [LN][NM+1];
    logic                 neg_reg [LN][NM+1];
    logic                 dz_reg  [LN][NM+1];
    logic                 vld_reg [NM+1];
    logic                 fs_reg  [NM+1];
    logic                 gt_reg  [NM+1];

    logic [DM:0]          t_w    [LN][NM+1];
    logic [DM:0]          diff_w [LN][NM+1];
    logic                 ge_w   [LN][NM+1];

    logic signed [NW-1:0] qm   [LN];
    logic signed [NW-1:0] qfin [LN];

    logic                 out_vld_reg;
    logic                 out_fs_reg;
    logic                 out_gt_reg;
    logic signed [NW-1:0] out_q0_reg;
    logic signed [NW-1:0] out_q1_reg;

    assign num_l[0] = din.num0;
    assign num_l[1] = din.num1;
    assign den_l[0] = din.den0;
    assign den_l[1] = din.den1;

    for (genvar l = 0; l < LN; l++)
    begin : g_lane
        assign num_neg[l] = -num_l[l];
        assign den_neg[l] = -den_l[l];
        assign nmag[l] = num_l[l][NW-1] ? num_neg[l][NM-1:0] : num_l[l][NM-1:0];
        assign dmag[l] = den_l[l][DW-1] ? den_neg[l][DM-1:0] : den_l[l][DM-1:0];

        assign t_w[l][0]    = '0;
        assign diff_w[l][0] = '0;
        assign ge_w[l][0]   = 1'b0;
        for (genvar k = 1; k <= NM; k++)
        begin : g_step
            assign t_w[l][k]    = {r_reg[l][k-1], n_reg[l][k-1][NM-1]};
            assign diff_w[l][k] = t_w[l][k] - {1'b0, d_reg[l][k-1]};
            assign ge_w[l][k]   = t_w[l][k] >= {1'b0, d_reg[l][k-1]};
        end

        assign qm[l]   = $signed({1'b0, n_reg[l][NM]});
        assign qfin[l] = dz_reg[l][NM] ? '0 : (neg_reg[l][NM] ? -qm[l] : qm[l]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= NM; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[0] <= din.valid;
            for (int k = 1; k <= NM; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
            out_vld_reg <= vld_reg[NM];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            fs_reg[0] <= din.fs;
            gt_reg[0] <= din.gt;
            for (int k = 1; k <= NM; k++)
            begin
                fs_reg[k] <= fs_reg[k-1];
                gt_reg[k] <= gt_reg[k-1];
            end
            for (int l = 0; l < LN; l++)
            begin
                n_reg[l][0]   <= nmag[l];
                r_reg[l][0]   <= '0;
                d_reg[l][0]   <= dmag[l];
                neg_reg[l][0] <= num_l[l][NW-1] ^ den_l[l][DW-1];
                dz_reg[l][0]  <= (den_l[l] == '0);
                for (int k = 1; k <= NM; k++)
                begin
                    n_reg[l][k]   <= {n_reg[l][k-1][NM-2:0], ge_w[l][k]};
                    r_reg[l][k]   <= ge_w[l][k] ? diff_w[l][k][DM-1:0] : t_w[l][k][DM-1:0];
                    d_reg[l][k]   <= d_reg[l][k-1];
                    neg_reg[l][k] <= neg_reg[l][k-1];
                    dz_reg[l][k]  <= dz_reg[l][k-1];
                end
            end
            out_fs_reg <= fs_reg[NM];
            out_gt_reg <= gt_reg[NM];
            out_q0_reg <= qfin[0];
            out_q1_reg <= qfin[1];
        end
    end

    assign dout = '{valid: out_vld_reg, fs: out_fs_reg, gt: out_gt_reg,
                    q0: out_q0_reg, q1: out_q1_reg};

endmodule

### rtl/rcps_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcps_back
// Final offset, dead-band and span handling, output clamp and the output
// register.
// ----------------------------------------------------------------------------
module rcps_back (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 adv,
    input  rcps_pkg::cfg_t                       cfg,
    input  rcps_pkg::div_out_t                   din,
    output logic                                 out_valid,
    output logic signed [rcps_pkg::CTL_W-1:0]    control_value,
    output logic                                 failsafe,
    output logic [rcps_pkg::PULSE_W-1:0]         pulse_out
);

    localparam int EW = rcps_pkg::EXT_W;
    localparam int PW = rcps_pkg::PULSE_W;
    localparam int CW = rcps_pkg::CTL_W;
    localparam int NW = rcps_pkg::NUM_W;
    localparam int OW = NW + 2;

    logic signed [EW-1:0] min_e, max_e, trim_e, db_e;
    logic                 zspan;
    logic signed [CW-1:0] rng_raw, rng_ctl, ctl_next;
    logic signed [OW-1:0] q1_o, min_o, max_o, trim_o, base_o, po;
    logic                 sub_d, is_range;
    logic [PW-1:0]        po_next;

    logic                 out_valid_reg;
    logic signed [CW-1:0] ctl_reg;
    logic                 fs_reg;
    logic [PW-1:0]        po_reg;

    always_comb
    begin
        min_e  = $signed({{(EW-PW){1'b0}}, cfg.pulse_min});
        max_e  = $signed({{(EW-PW){1'b0}}, cfg.pulse_max});
        trim_e = $signed({{(EW-PW){1'b0}}, cfg.pulse_trim});
        db_e   = $signed({{(EW-rcps_pkg::DB_W){1'b0}}, cfg.dead_band});
        zspan  = ((trim_e - db_e) == min_e) || (max_e == (trim_e + db_e));

        is_range = (cfg.channel_mode == rcps_pkg::MODE_RANGE);

        // Only the low bits of the range sum survive the 16-bit truncation.
        rng_raw = din.gt ? (cfg.scale_low + din.q0[CW-1:0]) :
                  ((cfg.dead_band != '0) ? '0 : cfg.scale_low);
        rng_ctl = (rng_raw < $signed({{(CW-rcps_pkg::DB_W){1'b0}}, cfg.dead_band})) ?
                  '0 : rng_raw;
        if (is_range)
        begin
            ctl_next = rng_ctl;
        end
        else
        begin
            ctl_next = zspan ? '0 : din.q0[CW-1:0];
        end

        q1_o   = {{(OW-NW){din.q1[NW-1]}}, din.q1};
        min_o  = $signed({{(OW-PW){1'b0}}, cfg.pulse_min});
        max_o  = $signed({{(OW-PW){1'b0}}, cfg.pulse_max});
        trim_o = $signed({{(OW-PW){1'b0}}, cfg.pulse_trim});
        sub_d  = cfg.reversed && (is_range || (cfg.channel_mode == rcps_pkg::MODE_RAW));
        if (is_range)
        begin
            base_o = cfg.reversed ? max_o : min_o;
        end
        else
        begin
            base_o = trim_o;
        end
        po = sub_d ? (base_o - q1_o) : (base_o + q1_o);

        // Minimum is tested first so a min above max still resolves.
        if (po <= min_o)
        begin
            po_next = cfg.pulse_min;
        end
        else if (po >= max_o)
        begin
            po_next = cfg.pulse_max;
        end
        else
        begin
            po_next = po[PW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= din.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ctl_reg <= ctl_next;
            fs_reg  <= din.fs;
            po_reg  <= po_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign control_value = ctl_reg;
    assign failsafe      = fs_reg;
    assign pulse_out     = po_reg;

endmodule

### rtl/rc_pwm_channel_scaler_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc_pwm_channel_scaler_core
// Throughput: one word per cycle; the pipeline holds as a whole only while
// the output register is full and the sink does not take it.
// Most stages lie in the divider, which resolves one quotient bit per stage.
// Reset (rst_n, asynchronous, active low) empties the pipeline and loads the
// register defaults.
// ----------------------------------------------------------------------------
module rc_pwm_channel_scaler_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [rcps_pkg::ADDR_W-1:0]    paddr,
    input  logic [rcps_pkg::DATA_W-1:0]    pwdata,
    output logic [rcps_pkg::DATA_W-1:0]    prdata,
    output logic                           pready,
    rcps_in_if.sink                        in_ch,
    rcps_out_if.source                     out_ch
);

    // The user must change the configuration only while the pipeline is empty;
    // the block does not enforce it. Stages read live registers, not copies.
    rcps_pkg::cfg_t     cfg;
    rcps_pkg::div_in_t  div_in;
    rcps_pkg::div_out_t div_out;
    logic               out_valid;
    logic               adv;

    // All stages move together. When the output register holds a word that
    // the sink has not taken, everything stands still, so no word is lost
    // or repeated; otherwise a new word enters on every cycle.
    assign adv          = !out_valid || out_ch.ready;
    assign in_ch.ready  = adv;
    assign out_ch.valid = out_valid;

    rcps_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Clamp, operand selection and the two multiplies.
    rcps_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .cfg       (cfg),
        .in_valid  (in_ch.valid),
        .pulse_in  (in_ch.pulse_in),
        .servo_cmd (in_ch.servo_cmd),
        .dout      (div_in)
    );

    // Lane 0 divides for the control value, lane 1 for the output pulse.
    rcps_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .adv   (adv),
        .din   (div_in),
        .dout  (div_out)
    );

    // Offsets, dead band, output clamp and the output register.
    rcps_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .adv           (adv),
        .cfg           (cfg),
        .din           (div_out),
        .out_valid     (out_valid),
        .control_value (out_ch.control_value),
        .failsafe      (out_ch.failsafe),
        .pulse_out     (out_ch.pulse_out)
    );

endmodule

### rtl/rcps_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcps_checker
// Port-level checks on the channel scaler, attached by bind.
// ----------------------------------------------------------------------------
module rcps_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_ready,
    input  logic                                 out_valid,
    input  logic                                 out_ready,
    input  logic signed [rcps_pkg::CTL_W-1:0]    control_value,
    input  logic [rcps_pkg::PULSE_W-1:0]         pulse_out,
    input  logic                                 pready
);

    // A word waiting at the output stays until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output word dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(control_value) && $stable(pulse_out))
        else $error("output word changed while stalled");

    // The input side only waits for a full, untaken output word.
    a_ready_rule: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("input ready does not follow the output stall");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("configuration port inserted wait states");

endmodule

bind rc_pwm_channel_scaler_core rcps_checker u_rcps_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ready      (in_ch.ready),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .control_value (out_ch.control_value),
    .pulse_out     (out_ch.pulse_out),
    .pready        (pready)
);

### dv/rcps_scoreboard.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcps_scoreboard
// Watches the configuration port and both channels of the RC channel scaler,
// predicts each result word from the accepted input word and the register
// values, and compares the results in order.
// ----------------------------------------------------------------------------
module rcps_scoreboard (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic                          pready,
    input  logic [rcps_pkg::ADDR_W-1:0]   paddr,
    input  logic [rcps_pkg::DATA_W-1:0]   pwdata,
    rcps_in_if                            in_ch,
    rcps_out_if                           out_ch,
    output int                            fail_count,
    output int                            pending
);
    import rcps_pkg::*;

    typedef struct packed {
        logic signed [CTL_W-1:0] ctl;
        logic                    fs;
        logic [PULSE_W-1:0]      po;
    } scaled_t;

    cfg_t    cfg;
    scaled_t expected_q[$];

    function automatic longint div0(longint a, longint b);
        return (b == 0) ? 0 : a / b;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        if (v <= lo) return lo;
        if (v >= hi) return hi;
        return v;
    endfunction

    function automatic longint wrap16(longint v);
        logic signed [15:0] t;
        t = v[15:0];
        return t;
    endfunction

    function automatic scaled_t scale_word(logic [PULSE_W-1:0] pin, logic signed [15:0] cmd);
        scaled_t r;
        longint p, s, hi, lo, db, mn, mx, tr, ctl, po, d, x, tl, th;
        p = pin; s = cmd; hi = cfg.scale_high; lo = cfg.scale_low;
        db = cfg.dead_band; mn = cfg.pulse_min; mx = cfg.pulse_max; tr = cfg.pulse_trim;
        if (cfg.channel_mode == MODE_RANGE) begin
            x = clip(p, mn, mx);
            tl = mn + db;
            if (cfg.reversed) x = mx - (x - mn);
            if (x > tl) ctl = wrap16(lo + div0((hi - lo) * (x - tl), mx - tl));
            else ctl = (db > 0) ? 0 : wrap16(lo);
            if (ctl < db) ctl = 0;
        end
        else begin
            th = tr + db;
            tl = tr - db;
            if (tl == mn || mx == th) ctl = 0;
            else if (p < tr) ctl = wrap16(div0(hi * (p - tr), tr - mn));
            else ctl = wrap16(div0(hi * (p - tr), mx - tr));
        end
        if (cfg.channel_mode == MODE_RANGE) begin
            d = div0((s - lo) * (mx - mn), hi - lo);
            po = cfg.reversed ? mx - d : mn + d;
        end
        else if (cfg.channel_mode == MODE_RAW) begin
            d = s / RAW_DIVISOR;
            po = (cfg.reversed ? -d : d) + tr;
        end
        else begin
            if (s > 0) d = div0(s * (mx - tr), hi);
            else d = div0(s * (tr - mn), hi);
            po = d + tr;
        end
        po = clip(po, mn, mx);
        r.ctl = ctl[15:0];
        r.fs = (p < mn - FAILSAFE_MARGIN);
        r.po = po[PULSE_W-1:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        scaled_t e;
        int      errs;
        if (!rst_n) begin
            cfg <= '{MODE_ANGLE, 16'sd4500, 16'sd0, 1'b0, 10'd0, 12'd1100, 12'd1900, 12'd1500};
            fail_count <= 0;
            pending <= 0;
            expected_q.delete();
        end
        else begin
            errs = 0;
            if (in_ch.valid && in_ch.ready)
                expected_q.push_back(scale_word(in_ch.pulse_in, in_ch.servo_cmd));
            if (out_ch.valid && out_ch.ready) begin
                if (expected_q.size() == 0) begin
                    $error("result word with no expectation");
                    errs = errs + 1;
                end
                else begin
                    e = expected_q.pop_front();
                    if (e.ctl !== out_ch.control_value) begin
                        $error("control_value exp %0d got %0d", e.ctl, out_ch.control_value);
                        errs = errs + 1;
                    end
                    if (e.fs !== out_ch.failsafe) begin
                        $error("failsafe exp %0d got %0d", e.fs, out_ch.failsafe);
                        errs = errs + 1;
                    end
                    if (e.po !== out_ch.pulse_out) begin
                        $error("pulse_out exp %0d got %0d", e.po, out_ch.pulse_out);
                        errs = errs + 1;
                    end
                end
            end
            fail_count <= fail_count + errs;
            pending <= expected_q.size();
            if (psel && penable && pwrite && pready) begin
                case (reg_idx_t'(paddr[ADDR_W-1:2]))
                    REG_CHANNEL_MODE: cfg.channel_mode <= mode_t'(pwdata[1:0]);
                    REG_SCALE_HIGH:   cfg.scale_high   <= pwdata[15:0];
                    REG_SCALE_LOW:    cfg.scale_low    <= pwdata[15:0];
                    REG_REVERSED:     cfg.reversed     <= pwdata[0];
                    REG_DEAD_BAND:    cfg.dead_band    <= pwdata[9:0];
                    REG_PULSE_MIN:    cfg.pulse_min    <= pwdata[11:0];
                    REG_PULSE_MAX:    cfg.pulse_max    <= pwdata[11:0];
                    REG_PULSE_TRIM:   cfg.pulse_trim   <= pwdata[11:0];
                    default:          ;
                endcase
            end
        end
    end
endmodule

### dv/tb_rc_pwm_channel_scaler_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rc_pwm_channel_scaler_core
// Drives input words through the RC channel scaler under several register
// settings, with random idling on both channels and a long output stall.
// A scoreboard module predicts and checks every result word.
// ----------------------------------------------------------------------------
module tb_rc_pwm_channel_scaler_core;
    import rcps_pkg::*;

    // DRAIN_CYCLES is a margin well above the depth of the pipeline; it is used
    // for the final drain and before a register write.
    localparam int DRAIN_CYCLES = 80;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic pready;
    int fail_count;
    int pending;

    // Idle chances, in percent, for the sender and the receiver.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    // While set, the receiver stalls completely.
    bit hold_results = 1'b0;

    rcps_in_if  in_ch ();
    rcps_out_if out_ch ();

    rc_pwm_channel_scaler_core i_dut (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_ch(in_ch.sink), .out_ch(out_ch.source)
    );

    rcps_scoreboard i_scoreboard (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .pready(pready), .paddr(paddr), .pwdata(pwdata), .in_ch(in_ch),
        .out_ch(out_ch), .fail_count(fail_count), .pending(pending)
    );

    always #5 clk = ~clk;

    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.pulse_in = '0;
        in_ch.servo_cmd = '0;
        out_ch.ready = 1'b0;
    end

    // The receiver decides its ready once per cycle.
    always @(posedge clk)
    begin
        if (rst_n)
            out_ch.ready <= !hold_results && ($urandom_range(99) >= recv_idle_pct);
    end

    // One APB write: setup cycle, then access cycle.
    task automatic write_reg(reg_idx_t idx, logic [DATA_W-1:0] value);
        @(posedge clk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= ADDR_W'(idx) << 2; pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    // Stops offering, waits until every expected word has come, then lets
    // the pipeline settle.
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Offers one word and holds it until it is taken; idles at random first.
    // The valid line stays high after the handshake so that the next word can
    // follow directly; idling and draining lower it.
    task automatic send_word(logic [PULSE_W-1:0] p, logic signed [15:0] s);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.pulse_in <= p;
        in_ch.servo_cmd <= s;
        do @(posedge clk); while (!in_ch.ready);
    endtask

    task automatic load_config(logic [1:0] mode, logic [15:0] hi, logic [15:0] lo,
                               logic rev, logic [9:0] db, logic [11:0] mn,
                               logic [11:0] mx, logic [11:0] tr);
        drain_results();
        write_reg(REG_CHANNEL_MODE, DATA_W'(mode));
        write_reg(REG_SCALE_HIGH, DATA_W'(hi));
        write_reg(REG_SCALE_LOW, DATA_W'(lo));
        write_reg(REG_REVERSED, DATA_W'(rev));
        write_reg(REG_DEAD_BAND, DATA_W'(db));
        write_reg(REG_PULSE_MIN, DATA_W'(mn));
        write_reg(REG_PULSE_MAX, DATA_W'(mx));
        write_reg(REG_PULSE_TRIM, DATA_W'(tr));
    endtask

    // Random words: pulses mostly near the calibrated span, sometimes anywhere.
    task automatic send_random(int count);
        logic [PULSE_W-1:0] p;
        logic [15:0] s;
        for (int k = 0; k < count; k++)
        begin
            p = ($urandom_range(3) == 0) ? PULSE_W'($urandom) : PULSE_W'($urandom_range(2100, 900));
            s = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(10000) - 5000);
            send_word(p, s);
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words under the reset settings: field extremes and the
        // failsafe edge around min minus the margin.
        send_word(12'd0, 16'sh8000);
        send_word(12'hFFF, 16'sh7FFF);
        send_word(12'd1049, 16'sd0);
        send_word(12'd1050, -16'sd1);
        send_word(12'd1500, 16'sd4500);
        send_word(12'd1100, -16'sd4500);
        send_word(12'd1900, 16'sd1);

        // Range mode with a dead band, reversed, and a zero output divisor.
        load_config(MODE_RANGE, 16'd1000, 16'd1000, 1'b1, 10'd20, 12'd1000, 12'd2000, 12'd1500);
        send_word(12'd1010, 16'sd5);
        send_word(12'd1500, 16'sh8000);
        send_word(12'd2000, 16'sh7FFF);
        // Range mode with no dead band and min above max.
        load_config(MODE_RANGE, 16'h7FFF, 16'h8000, 1'b0, 10'd0, 12'd2000, 12'd1000, 12'd1500);
        send_word(12'd1500, 16'sd0);
        send_word(12'd3000, 16'sh8000);
        send_word(12'd0, 16'sh7FFF);
        // Angle with a zero span, then mode three and raw mode.
        load_config(MODE_ANGLE, 16'd4500, 16'd0, 1'b0, 10'd100, 12'd1400, 12'd1900, 12'd1500);
        send_word(12'd1700, 16'sd100);
        load_config(MODE_ANGLE_ALT, 16'd0, 16'd0, 1'b1, 10'd0, 12'd1000, 12'd2000, 12'd1500);
        send_word(12'd1200, 16'sd300);
        send_word(12'd1800, -16'sd300);
        load_config(MODE_RAW, 16'd4500, 16'd0, 1'b1, 10'h3FF, 12'd0, 12'hFFF, 12'hFFF);
        send_word(12'd77, 16'sh7FFF);
        send_word(12'd10, 16'sh8000);
        send_word(12'd1023, -16'sd19);

        // Random phases, each under new random settings.
        for (int ph = 0; ph < 10; ph++)
        begin
            if (ph < 4) begin send_idle_pct = 23; recv_idle_pct = 54; end
            else if (ph < 7) begin send_idle_pct = 54; recv_idle_pct = 23; end
            else begin send_idle_pct = 0; recv_idle_pct = 0; end
            if (ph % 3 == 0)
                load_config(2'($urandom), 16'($urandom), 16'($urandom), 1'($urandom),
                            10'($urandom), 12'($urandom), 12'($urandom), 12'($urandom));
            else
                load_config(2'($urandom), 16'($urandom_range(9000) - 4500),
                            16'($urandom_range(2000) - 1000), 1'($urandom),
                            10'($urandom_range(80)), 12'($urandom_range(1200, 900)),
                            12'($urandom_range(2100, 1800)), 12'($urandom_range(1600, 1400)));
            if (ph == 5)
            begin
                // Long output stall while the sender keeps offering words.
                hold_results = 1'b1;
                fork
                    begin
                        repeat (300) @(posedge clk);
                        hold_results = 1'b0;
                    end
                join_none
            end
            send_random(48);
        end

        drain_results();
        if (fail_count == 0)
            $display("tb_rc_pwm_channel_scaler_core: clean");
        else
            $display("tb_rc_pwm_channel_scaler_core: errors");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("tb_rc_pwm_channel_scaler_core: errors");
        $finish;
    end
endmodule
